>>> rtl/wmss_pkg.sv
// shared constants, types and state encoding for the windowed max smoothed scale block
package wmss_pkg;

    // ring store geometry
    localparam int WINDOW_DEPTH = 256;
    localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
    localparam int LEN_BITS     = ADDR_BITS + 1;

    // sample and arithmetic widths
    localparam int SAMPLE_BITS = 32;
    localparam int GAIN_BITS   = 16;
    localparam int PROD_BITS   = GAIN_BITS + SAMPLE_BITS;
    localparam int FRAC_BITS   = 16;
    localparam int ALPHA_BITS  = FRAC_BITS + 1;
    localparam int MIX_BITS    = ALPHA_BITS + SAMPLE_BITS;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1) << FRAC_BITS;

    // configuration port
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_ADAPT_GAIN    = CFG_IDX_BITS'(1);

    localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(215);
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(2560);

    // stream widths
    localparam int S_DATA_BITS = SAMPLE_BITS;
    localparam int M_DATA_BITS = 2 * SAMPLE_BITS;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_MIX
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic ring_write;
        logic scan_step;
        logic mul;
        logic mix;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

>>> rtl/wmss_ram.sv
// generic single write port ram with registered read
module wmss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/wmss_ctrl.sv
// sequencing state machine: capture, ring write, window scan, drain, multiply, mix
module wmss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  wmss_pkg::status_t status,
    output wmss_pkg::cmd_t    cmd
);

    wmss_pkg::state_t state_reg;
    wmss_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wmss_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        case (state_reg)
            wmss_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = wmss_pkg::ST_WRITE;
                end
            end
            wmss_pkg::ST_WRITE: begin
                cmd.ring_write = 1'b1;
                state_next     = wmss_pkg::ST_SCAN;
            end
            wmss_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = wmss_pkg::ST_DRAIN;
                end
            end
            wmss_pkg::ST_DRAIN: begin
                state_next = wmss_pkg::ST_MUL;
            end
            wmss_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = wmss_pkg::ST_MIX;
            end
            wmss_pkg::ST_MIX: begin
                // wait here until the output register can take the result
                if (status.out_free) begin
                    cmd.mix    = 1'b1;
                    state_next = wmss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wmss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/wmss_datapath.sv
// ring store, window max scan, smoothing arithmetic, config registers and output register
module wmss_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wmss_pkg::cmd_t                       cmd,
    output wmss_pkg::status_t                    status,
    input  logic [wmss_pkg::S_DATA_BITS-1:0]     s_tdata,
    input  logic                                 cfg_valid,
    input  logic [wmss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [wmss_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wmss_pkg::M_DATA_BITS-1:0]     m_tdata
);

    localparam int AW = wmss_pkg::ADDR_BITS;
    localparam int LW = wmss_pkg::LEN_BITS;
    localparam int SW = wmss_pkg::SAMPLE_BITS;

    // configuration registers
    logic [LW-1:0]                  win_len_reg;
    logic [wmss_pkg::GAIN_BITS-1:0] gain_reg;

    // ring control
    logic [wmss_pkg::WINDOW_DEPTH-1:0] valid_reg;
    logic [AW-1:0]                     pos_reg;
    logic [AW-1:0]                     addr_reg;
    logic                              rd_pend_reg;
    logic                              rd_vld_reg;

    // payload
    logic [SW-1:0]                      sample_reg;
    logic [SW-1:0]                      max_reg;
    logic [SW-1:0]                      scale_reg;
    logic [wmss_pkg::PROD_BITS-1:0]     prod_reg;
    logic [wmss_pkg::ALPHA_BITS-1:0]    alpha_reg;
    logic [wmss_pkg::MIX_BITS-1:0]      keep_reg;
    logic [wmss_pkg::MIX_BITS-1:0]      pull_reg;
    logic [SW-1:0]                      out_scale_reg;
    logic [SW-1:0]                      out_max_reg;
    logic                               out_valid_reg;

    logic [LW-1:0]                  len_eff;
    logic [AW-1:0]                  last_idx;
    logic [AW-1:0]                  pos_eff;
    logic [AW-1:0]                  pos_next;
    logic [SW-1:0]                  ram_q;
    logic [SW-1:0]                  scan_val;
    logic [wmss_pkg::ALPHA_BITS-1:0] alpha_sat;
    logic [wmss_pkg::MIX_BITS:0]    mix_sum;
    logic [SW-1:0]                  scale_new;
    logic                           len_write;

    // active length, zero acts as one and anything past the ring depth as the depth
    always_comb begin
        if (win_len_reg == '0) begin
            len_eff = LW'(1);
        end else if (win_len_reg > LW'(wmss_pkg::WINDOW_DEPTH)) begin
            len_eff = LW'(wmss_pkg::WINDOW_DEPTH);
        end else begin
            len_eff = win_len_reg;
        end
    end

    assign last_idx = AW'(len_eff - LW'(1));

    // write position wraps after the last active entry
    assign pos_eff  = ({1'b0, pos_reg} >= len_eff) ? '0 : pos_reg;
    assign pos_next = (pos_eff == last_idx) ? '0 : pos_eff + AW'(1);

    assign len_write = cfg_valid && (cfg_index == wmss_pkg::REG_WINDOW_LENGTH);

    // configuration writes, a length write also empties the ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= wmss_pkg::LEN_RESET;
            gain_reg    <= wmss_pkg::GAIN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                wmss_pkg::REG_WINDOW_LENGTH: win_len_reg <= cfg_data[LW-1:0];
                wmss_pkg::REG_ADAPT_GAIN:    gain_reg    <= cfg_data[wmss_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // entry valid bits and write position
    always_ff @(posedge aclk) begin
        if (!aresetn || len_write) begin
            valid_reg <= '0;
            pos_reg   <= '0;
        end else if (cmd.ring_write) begin
            valid_reg[pos_eff] <= 1'b1;
            pos_reg            <= pos_next;
        end
    end

    // sample store
    wmss_ram #(
        .WIDTH (SW),
        .DEPTH (wmss_pkg::WINDOW_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.ring_write),
        .waddr (pos_eff),
        .wdata (sample_reg),
        .re    (cmd.scan_step),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // scan address and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan_step;
            if (cmd.ring_write) begin
                addr_reg <= '0;
            end else if (cmd.scan_step) begin
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    // valid bit travels with the ram read
    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            rd_vld_reg <= valid_reg[addr_reg];
        end
    end

    // never written entries read as zero
    assign scan_val = rd_vld_reg ? ram_q : '0;

    // sample capture and running maximum
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= s_tdata[SW-1:0];
        end
        if (cmd.ring_write) begin
            max_reg <= '0;
        end else if (rd_pend_reg && (scan_val > max_reg)) begin
            max_reg <= scan_val;
        end
    end

    // smoothing weight, gain times sample then truncated and saturated at one
    assign alpha_sat = (prod_reg[wmss_pkg::PROD_BITS-1:wmss_pkg::FRAC_BITS]
                        > (wmss_pkg::PROD_BITS - wmss_pkg::FRAC_BITS)'(wmss_pkg::ALPHA_ONE))
                       ? wmss_pkg::ALPHA_ONE
                       : prod_reg[wmss_pkg::ALPHA_BITS+wmss_pkg::FRAC_BITS-1:wmss_pkg::FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (cmd.ring_write) begin
            prod_reg <= wmss_pkg::PROD_BITS'(gain_reg) * wmss_pkg::PROD_BITS'(sample_reg);
        end
        if (cmd.scan_step) begin
            alpha_reg <= alpha_sat;
        end
    end

    // the two weighted terms
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            keep_reg <= wmss_pkg::MIX_BITS'(wmss_pkg::ALPHA_ONE - alpha_reg)
                        * wmss_pkg::MIX_BITS'(scale_reg);
            pull_reg <= wmss_pkg::MIX_BITS'(alpha_reg) * wmss_pkg::MIX_BITS'(max_reg);
        end
    end

    assign mix_sum   = {1'b0, keep_reg} + {1'b0, pull_reg};
    assign scale_new = mix_sum[SW+wmss_pkg::FRAC_BITS-1:wmss_pkg::FRAC_BITS];

    // scale state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= '0;
        end else if (cmd.mix) begin
            scale_reg <= scale_new;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.mix) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mix) begin
            out_scale_reg <= scale_new;
            out_max_reg   <= max_reg;
        end
    end

    assign status.scan_last = (addr_reg == last_idx);
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_max_reg, out_scale_reg};

endmodule

>>> rtl/windowed_max_smoothed_scale.sv
// top level of the auto-ranging display scale with sliding window max and smoothing
//
//  channel  direction  handshake           payload
//  s_       in         s_tvalid/s_tready   s_tdata[31:0] sample_time
//  m_       out        m_tvalid/m_tready   m_tdata[31:0] smoothed_scale, [63:32] window_max
//  cfg_     in         cfg_valid/cfg_ready cfg_index 0 window_length, 1 adapt_gain; cfg_data
//
// the time from a sample's transfer to its result grows with the window length, set by the
// scan that reads the ring one entry a cycle through the single ram read port.
// the output register holds a result while the next sample is taken in and processed;
// the block only stalls at the final mix step if that register is still full.
// reset is synchronous and active low; entry valid bits make the ring read as zero at once.
// a window_length write also empties the ring and returns the write position to zero.
module windowed_max_smoothed_scale (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample_time [31:0]
    input  logic [wmss_pkg::S_DATA_BITS-1:0]   s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // smoothed_scale [31:0], window_max [63:32]
    output logic [wmss_pkg::M_DATA_BITS-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wmss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wmss_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    wmss_pkg::cmd_t    cmd;
    wmss_pkg::status_t status;

    // configuration transfers are always taken
    assign cfg_ready = 1'b1;

    wmss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wmss_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
